/* sv/smbpec_pkg.sv */
// smbpec_pkg: shared types, codes and the CRC-8 byte fold for the SMBus PEC engine.
// No dependencies; imported by every module of the block.
package smbpec_pkg;

    localparam logic [7:0] PEC_POLY  = 8'h07;
    localparam logic [7:0] PEC_TOP   = 8'h80;
    localparam int         PEC_BITS  = 8;
    localparam logic [7:0] SHORT_MAX = 8'd2;

    typedef enum logic [2:0] {
        REQ_OPEN   = 3'd0,
        REQ_CMD    = 3'd1,
        REQ_TURN   = 3'd2,
        REQ_DATA   = 3'd3,
        REQ_FINISH = 3'd4
    } t_req;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_WRITE = 2'd1,
        PH_READ  = 2'd2,
        PH_DONE  = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ST_PENDING  = 2'd0,
        ST_MATCH    = 2'd1,
        ST_MISMATCH = 2'd2,
        ST_LEN_ERR  = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        t_status    status;
    } t_result;

    // Fold one byte into the CRC, MSB first.
    function automatic logic [7:0] pec_fold(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < PEC_BITS; k++) begin
            if ((c & PEC_TOP) != 8'd0) begin
                c = {c[6:0], 1'b0} ^ PEC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* sv/smbus_pec_generate_check_unit.sv */
// smbus_pec_generate_check_unit: top level of the SMBus PEC generate/check engine.
// Depends on smbpec_pkg and smbpec_engine.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------------
//  req     | in        | i_req_valid/o_req_stall | i_req_type, i_data_byte, i_read_len
//  res     | out       | o_res_valid/i_res_stall | o_out_byte, o_out_valid, o_status
//  cfg     | in        | i_cfg_valid/o_cfg_ready | i_cfg_data (slave address)
//
// Each request transfer loads one result, offered on o_res_valid the next cycle.
// One request per cycle is sustained while no result is stalled: the CRC fold and phase
// update sit between the transfer state and the result register, which is the only stage.
// Reset (synchronous, i_rst_n low) clears the phase, CRC, read position,
// slave address and result valid.
// A stalled result holds; the request side stalls only while it waits untaken.
module smbus_pec_generate_check_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // request channel
    input  logic       i_req_valid,
    output logic       o_req_stall,
    input  logic [2:0] i_req_type,
    input  logic [7:0] i_data_byte,
    input  logic [7:0] i_read_len,
    // result channel
    output logic       o_res_valid,
    input  logic       i_res_stall,
    output logic [7:0] o_out_byte,
    output logic       o_out_valid,
    output logic [1:0] o_status,
    // configuration channel
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [6:0] i_cfg_data
);
    import smbpec_pkg::*;

    logic       accept;
    t_result    result;
    t_result    r_res;
    logic       r_res_valid;
    logic [6:0] r_addr;

    // Stall the request side only when a result is parked and still stalled
    assign o_req_stall = r_res_valid && i_res_stall;
    assign accept      = i_req_valid && !o_req_stall;

    // Config writes are taken at any time; the user writes only when idle
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= 7'd0;
        end else if (i_cfg_valid) begin
            r_addr <= i_cfg_data;
        end
    end

    smbpec_engine u_engine (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_req_type      (i_req_type),
        .i_data_byte     (i_data_byte),
        .i_read_len      (i_read_len),
        .i_slave_address (r_addr),
        .o_result        (result)
    );

    // Result register: load on every request transfer, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (accept) begin
            r_res_valid <= 1'b1;
        end else if (!i_res_stall) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= result;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_out_byte  = r_res.out_byte;
    assign o_out_valid = r_res.out_valid;
    assign o_status    = r_res.status;

endmodule

/* sv/smbpec_engine.sv */
// smbpec_engine: transfer state (phase, CRC, read position) and the per-byte result logic.
// Depends on smbpec_pkg.
module smbpec_engine (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic [2:0]             i_req_type,
    input  logic [7:0]             i_data_byte,
    input  logic [7:0]             i_read_len,
    input  logic [6:0]             i_slave_address,
    output smbpec_pkg::t_result    o_result
);
    import smbpec_pkg::*;

    t_phase     r_phase, n_phase;
    logic [7:0] r_crc, n_crc;
    logic [7:0] r_idx, n_idx;
    logic [8:0] r_pos, n_pos;
    logic [7:0] r_elen, n_elen;

    logic       is_open, in_write, fold_wr, finish, turn, rd;
    logic       blk_first, len_err, blk_ok, verdict, rd_fold;
    logic [7:0] fold_crc_in, fold_byte_in, fold_out;

    // Request decode against the current phase
    assign is_open   = (i_req_type == REQ_OPEN);
    assign in_write  = !is_open && (r_phase == PH_WRITE);
    assign fold_wr   = in_write && ((i_req_type == REQ_CMD) || (i_req_type == REQ_DATA));
    assign finish    = in_write && (i_req_type == REQ_FINISH);
    assign turn      = in_write && (i_req_type == REQ_TURN);
    assign rd        = !is_open && (r_phase == PH_READ) && (i_req_type == REQ_DATA);
    assign blk_first = rd && (r_elen > SHORT_MAX) && (r_idx == 8'd0);
    assign len_err   = blk_first && (i_data_byte >= r_elen);
    assign blk_ok    = blk_first && !len_err;
    assign verdict   = rd && !blk_first && ({1'b0, r_idx} == r_pos);
    assign rd_fold   = rd && !blk_first && !verdict;

    // One shared byte fold: address bytes or the data byte
    assign fold_crc_in  = is_open ? 8'd0 : r_crc;
    assign fold_byte_in = is_open ? {i_slave_address, 1'b0} :
                          turn    ? {i_slave_address, 1'b1} : i_data_byte;
    assign fold_out     = pec_fold(fold_crc_in, fold_byte_in);

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (i_accept) begin
            if (is_open) begin
                n_phase = PH_WRITE;
            end else if (finish) begin
                n_phase = PH_IDLE;
            end else if (turn) begin
                n_phase = PH_READ;
            end else if (len_err || verdict) begin
                n_phase = PH_DONE;
            end
        end
    end

    // Datapath state
    always_comb begin
        n_crc  = r_crc;
        n_idx  = r_idx;
        n_pos  = r_pos;
        n_elen = r_elen;
        if (i_accept) begin
            if (is_open) begin
                n_crc = fold_out;
                n_idx = 8'd0;
                n_pos = 9'd0;
            end else if (fold_wr) begin
                n_crc = fold_out;
            end else if (turn) begin
                n_crc  = fold_out;
                n_elen = i_read_len;
                n_idx  = 8'd0;
                n_pos  = (i_read_len > SHORT_MAX) ? 9'd0 : {1'b0, i_read_len};
            end else if (blk_ok) begin
                n_crc = fold_out;
                n_pos = {1'b0, i_data_byte} + 9'd1;
                n_idx = 8'd1;
            end else if (rd_fold) begin
                n_crc = fold_out;
                n_idx = r_idx + 8'd1;
            end
        end
    end

    // Result for this byte
    always_comb begin
        o_result = '{out_byte: 8'd0, out_valid: 1'b0, status: ST_PENDING};
        if (fold_wr || blk_ok || rd_fold) begin
            o_result.out_byte  = i_data_byte;
            o_result.out_valid = 1'b1;
        end else if (finish) begin
            o_result.out_byte  = r_crc;
            o_result.out_valid = 1'b1;
        end else if (verdict) begin
            o_result.out_byte = r_crc;
            o_result.status   = (i_data_byte == r_crc) ? ST_MATCH : ST_MISMATCH;
        end else if (len_err) begin
            o_result.status = ST_LEN_ERR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_crc   <= 8'd0;
            r_idx   <= 8'd0;
            r_pos   <= 9'd0;
            r_elen  <= 8'd0;
        end else begin
            r_phase <= n_phase;
            r_crc   <= n_crc;
            r_idx   <= n_idx;
            r_pos   <= n_pos;
            r_elen  <= n_elen;
        end
    end

endmodule

/* sv/smbpec_checker.sv */
// smbpec_checker: port-level assertions for the SMBus PEC engine, plus its bind.
// Depends on smbpec_pkg and smbus_pec_generate_check_unit.
module smbpec_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_req_valid,
    input logic       o_req_stall,
    input logic       o_res_valid,
    input logic       i_res_stall,
    input logic [7:0] o_out_byte,
    input logic       o_out_valid,
    input logic [1:0] o_status
);
    import smbpec_pkg::*;

    // A stalled result holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && i_res_stall |=> o_res_valid && $stable(o_out_byte)
            && $stable(o_out_valid) && $stable(o_status))
        else $error("stalled result changed");

    // Request side stalls only behind a waiting result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_req_stall |-> o_res_valid && i_res_stall)
        else $error("request stall without a stalled result");

    // Every request transfer produces a result next cycle
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && !o_req_stall |=> o_res_valid)
        else $error("request transfer without a result");

    // A delivered byte never carries a verdict
    a_byte_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_out_valid |-> o_status == ST_PENDING)
        else $error("byte delivered with a verdict");

    // Length error carries no byte
    a_len_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_status == ST_LEN_ERR |-> !o_out_valid && o_out_byte == 8'd0)
        else $error("length error with a byte");

endmodule

bind smbus_pec_generate_check_unit smbpec_checker u_smbpec_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req_valid),
    .o_req_stall (o_req_stall),
    .o_res_valid (o_res_valid),
    .i_res_stall (i_res_stall),
    .o_out_byte  (o_out_byte),
    .o_out_valid (o_out_valid),
    .o_status    (o_status)
);
